@@ rtl/cal_pkg.sv @@
package cal_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int CAPACITY_MAX = 256;

    localparam int DATA_W     = 8;
    localparam int MODE_W     = 4;
    localparam int POS_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int CURSOR_W   = 6;
    localparam int COUNT_W    = 6;
    localparam int CELL_IDX_W = $clog2(CAPACITY_MAX + 1);

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 4'd0,
        MODE_DELETE  = 4'd1,
        MODE_FRONT   = 4'd2,
        MODE_REAR    = 4'd3,
        MODE_PREV    = 4'd4,
        MODE_NEXT    = 4'd5,
        MODE_GET     = 4'd6,
        MODE_REPLACE = 4'd7,
        MODE_CLEAR   = 4'd8,
        MODE_MOVE    = 4'd9,
        MODE_UPPER   = 4'd10,
        MODE_LOWER   = 4'd11
    } mode_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    localparam logic [DATA_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [DATA_W-1:0] CH_LOWER_Z = 8'h7a;
    localparam logic [DATA_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [DATA_W-1:0] CH_UPPER_Z = 8'h5a;
    localparam logic [DATA_W-1:0] CASE_DIFF  = CH_LOWER_A - CH_UPPER_A;

    typedef struct packed {
        logic                  shr;
        logic                  shl;
        logic                  wr;
        logic [CELL_IDX_W-1:0] lo;
        logic [CELL_IDX_W-1:0] hi;
        logic [CELL_IDX_W-1:0] widx;
        logic [DATA_W-1:0]     wdata;
    } cell_cmd_t;

    function automatic logic [DATA_W-1:0] to_upper(input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        r = b;
        if (b >= CH_LOWER_A && b <= CH_LOWER_Z)
        begin
            r = b - CASE_DIFF;
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] to_lower(input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        r = b;
        if (b >= CH_UPPER_A && b <= CH_UPPER_Z)
        begin
            r = b + CASE_DIFF;
        end
        return r;
    endfunction

endpackage

@@ rtl/cal_cell.sv @@
module cal_cell
    import cal_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] left,
    input  logic [DATA_W-1:0] right,
    output logic [DATA_W-1:0] q
);

    localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (cmd.wr && cmd.widx == MY_IDX)
        begin
            data_next = cmd.wdata;
        end
        else if (cmd.shr && MY_IDX > cmd.lo && MY_IDX <= cmd.hi)
        begin
            data_next = left;
        end
        else if (cmd.shl && MY_IDX >= cmd.lo && MY_IDX < cmd.hi)
        begin
            data_next = right;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

@@ rtl/cursor_array_list.sv @@
// Byte list of up to CAPACITY entries with a cursor, held in a chain of byte cells
// that shift or rotate all at once. Each input item is one command (tdata: mode[3:0],
// data[11:4], position[16:12]); each produces exactly one output item (status[1:0],
// read_data[9:2], cursor[15:10], count[21:16]) describing the list after the
// command. The cell chain updates at acceptance and the byte at the new cursor is
// selected out of the chain in the following cycle. The next item is accepted once
// that result is registered and the output is free or draining. Cursor reads all
// ones when the list is empty; cursor and count are reported in six bits.
module cursor_array_list
    import cal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // mode, data, position
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // status, read_data, cursor, count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    typedef enum logic {S_IDLE, S_READ} state_t;

    state_t              state_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [IDX_W-1:0]    cur_reg;
    logic [IDX_W-1:0]    cur_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DATA_W-1:0]   cur_byte_reg;

    mode_t             in_mode;
    logic [DATA_W-1:0] in_data;
    logic [POS_W-1:0]  in_pos;
    logic              accept;
    logic              empty;
    logic              needs_list;
    logic [IDX_W-1:0]  last_idx;
    logic [IDX_W-1:0]  ins_idx;
    logic [IDX_W-1:0]  pos_idx;
    cell_cmd_t         op;
    cell_cmd_t         cmd;

    logic [DATA_W-1:0] cell_q [CAPACITY];
    logic [DATA_W-1:0] rd_byte;
    logic [CURSOR_W-1:0] out_cursor;

    assign in_mode = mode_t'(s_tdata[MODE_W-1:0]);
    assign in_data = s_tdata[MODE_W +: DATA_W];
    assign in_pos  = s_tdata[MODE_W+DATA_W +: POS_W];

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign empty    = (cnt_reg == '0);
    assign last_idx = IDX_W'(cnt_reg - CNT_W'(1));
    assign ins_idx  = empty ? '0 : cur_reg + IDX_W'(1);
    assign pos_idx  = IDX_W'(in_pos);

    assign needs_list = !(in_mode == MODE_INSERT || in_mode == MODE_CLEAR ||
                          s_tdata[MODE_W-1:0] > MODE_LOWER);

    always_comb
    begin
        status_next = ST_OK;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        op          = '0;
        if (empty && needs_list)
        begin
            status_next = ST_EMPTY;
        end
        else
        begin
            unique case (in_mode)
                MODE_INSERT:
                begin
                    if (cnt_reg == CNT_FULL)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        op.shr   = 1'b1;
                        op.lo    = CELL_IDX_W'(ins_idx);
                        op.hi    = CELL_IDX_W'(cnt_reg);
                        op.wr    = 1'b1;
                        op.widx  = CELL_IDX_W'(ins_idx);
                        op.wdata = in_data;
                        cur_next = ins_idx;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                MODE_DELETE:
                begin
                    op.shl = 1'b1;
                    op.lo  = CELL_IDX_W'(cur_reg);
                    op.hi  = CELL_IDX_W'(last_idx);
                    if (cur_reg == last_idx)
                    begin
                        cur_next = cur_reg - IDX_W'(1);
                    end
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                MODE_FRONT:
                begin
                    cur_next = '0;
                end
                MODE_REAR:
                begin
                    cur_next = last_idx;
                end
                MODE_PREV:
                begin
                    if (cur_reg != '0)
                    begin
                        cur_next = cur_reg - IDX_W'(1);
                    end
                end
                MODE_NEXT:
                begin
                    if (cur_reg != last_idx)
                    begin
                        cur_next = cur_reg + IDX_W'(1);
                    end
                end
                MODE_GET:
                begin
                end
                MODE_REPLACE:
                begin
                    op.wr    = 1'b1;
                    op.widx  = CELL_IDX_W'(cur_reg);
                    op.wdata = in_data;
                end
                MODE_CLEAR:
                begin
                    cnt_next = '0;
                    cur_next = '1;
                end
                MODE_MOVE:
                begin
                    if (CMP_W'(in_pos) >= CMP_W'(cnt_reg))
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        if (cur_reg > pos_idx)
                        begin
                            op.shr = 1'b1;
                            op.lo  = CELL_IDX_W'(pos_idx);
                            op.hi  = CELL_IDX_W'(cur_reg);
                        end
                        else
                        begin
                            op.shl = 1'b1;
                            op.lo  = CELL_IDX_W'(cur_reg);
                            op.hi  = CELL_IDX_W'(pos_idx);
                        end
                        op.wr    = 1'b1;
                        op.widx  = CELL_IDX_W'(pos_idx);
                        op.wdata = cur_byte_reg;
                        cur_next = pos_idx;
                    end
                end
                MODE_UPPER:
                begin
                    op.wr    = 1'b1;
                    op.widx  = CELL_IDX_W'(cur_reg);
                    op.wdata = to_upper(cur_byte_reg);
                end
                MODE_LOWER:
                begin
                    op.wr    = 1'b1;
                    op.widx  = CELL_IDX_W'(cur_reg);
                    op.wdata = to_lower(cur_byte_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cmd = accept ? op : '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_q;
        logic [DATA_W-1:0] right_q;
        if (g == 0)
        begin : g_first
            assign left_q = '0;
        end
        else
        begin : g_mid_l
            assign left_q = cell_q[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_q = '0;
        end
        else
        begin : g_mid_r
            assign right_q = cell_q[g+1];
        end
        cal_cell #(
            .INDEX (g)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .left  (left_q),
            .right (right_q),
            .q     (cell_q[g])
        );
    end

    assign rd_byte    = empty ? '0 : cell_q[cur_reg];
    assign out_cursor = empty ? '1 : CURSOR_W'(cur_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            cur_reg      <= '1;
            cnt_reg      <= '0;
            status_reg   <= ST_OK;
            cur_byte_reg <= '0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_reg    <= cur_next;
                        cnt_reg    <= cnt_next;
                        status_reg <= status_next;
                        state_reg  <= S_READ;
                    end
                end
                S_READ:
                begin
                    cur_byte_reg <= rd_byte;
                    m_tdata_reg  <= M_TDATA_W'({COUNT_W'(cnt_reg), out_cursor,
                                                rd_byte, status_reg});
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("item count beyond capacity");

    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> (CNT_W'(cur_reg) < cnt_reg))
        else $error("cursor outside the list");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 m_tvalid)
        else $error("accepted item produced no result");

    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("item accepted while chain result pending");
`endif

endmodule
